FILE: rtl/rbw_pkg.sv
// ----------------------------------------------------------------------------
// rbw_pkg
// Shared types, constants and codes of the rotation bilinear weight generator.
// ----------------------------------------------------------------------------
`default_nettype none

package rbw_pkg;

    localparam int REG_W         = 11;
    localparam int IDX_W         = 20;
    localparam int WGT_W         = 17;
    localparam int CMD_W         = 3;
    localparam int REG_IDX_W     = 2;
    localparam int FIFO_DEPTH    = 4;
    localparam int DEF_COORD_BITS = 10;
    localparam int DEF_FRAC_BITS  = 16;

    localparam logic [30:0]      SQRT3_Q30    = 31'd1859775393;
    localparam logic [WGT_W-1:0] WGT_ONE      = 17'd65536;

    localparam logic [REG_W-1:0] RST_GRID_W   = 11'd64;
    localparam logic [REG_W-1:0] RST_GRID_H   = 11'd64;
    localparam logic [REG_W-1:0] RST_DOM_W    = 11'd32;
    localparam logic [REG_W-1:0] RST_DOM_H    = 11'd32;

    typedef enum logic [CMD_W-1:0] {
        CMD_ROT_POS = 3'd0,
        CMD_ROT_NEG = 3'd1,
        CMD_SH_PP   = 3'd2,
        CMD_SH_PM   = 3'd3,
        CMD_SH_MP   = 3'd4,
        CMD_SH_MM   = 3'd5,
        CMD_FOLD    = 3'd6,
        CMD_NONE    = 3'd7
    } cmd_t;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_GRID_W = 2'd0,
        REG_GRID_H = 2'd1,
        REG_DOM_W  = 2'd2,
        REG_DOM_H  = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        KIND_ZERO = 2'd0,
        KIND_BIL  = 2'd1,
        KIND_FOLD = 2'd2
    } kind_t;

    typedef struct packed {
        logic [REG_W-1:0] grid_width;
        logic [REG_W-1:0] grid_height;
        logic [REG_W-1:0] domain_width;
        logic [REG_W-1:0] domain_height;
    } cfg_t;

    typedef struct packed {
        logic             in_range;
        logic [IDX_W-1:0] index_a;
        logic [IDX_W-1:0] index_b;
        logic [IDX_W-1:0] index_c;
        logic [IDX_W-1:0] index_d;
        logic [WGT_W-1:0] weight_a;
        logic [WGT_W-1:0] weight_b;
        logic [WGT_W-1:0] weight_c;
        logic [WGT_W-1:0] weight_d;
    } res_t;

endpackage

`default_nettype wire

FILE: rtl/rbw_fifo.sv
// ----------------------------------------------------------------------------
// rbw_fifo
// Small register queue with occupancy count.
// ----------------------------------------------------------------------------
`default_nettype none

module rbw_fifo
    import rbw_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = FIFO_DEPTH
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     wr_en,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    output logic      [WIDTH-1:0]         rd_data,
    output logic      [$clog2(DEPTH):0]   count,
    output logic                          empty
);

    localparam int PW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [PW:0]      cnt_reg, cnt_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en)
        begin
            wr_ptr_next = PW'(wr_ptr_reg + 1'b1);
        end
        if (rd_en)
        begin
            rd_ptr_next = PW'(rd_ptr_reg + 1'b1);
        end
        if (wr_en && !rd_en)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!wr_en && rd_en)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data = mem_reg[rd_ptr_reg];
    assign count   = cnt_reg;
    assign empty   = (cnt_reg == '0);

endmodule

`default_nettype wire

FILE: rtl/rbw_front.sv
// ----------------------------------------------------------------------------
// rbw_front
// Classifies the command, maps the pixel to a fixed-point source point or
// runs the fold domain test; three steps, result written to the mid queue.
// ----------------------------------------------------------------------------
`default_nettype none

module rbw_front
    import rbw_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire cfg_t                   cfg,
    input  wire logic                   in_vld,
    input  wire logic [CMD_W-1:0]       cmd,
    input  wire logic [COORD_BITS-1:0]  col,
    input  wire logic [COORD_BITS-1:0]  row,
    output logic                        mid_wr_en,
    output logic [2+2*(((COORD_BITS > REG_W) ? COORD_BITS : REG_W)+3+FRAC_BITS)+IDX_W-1:0]
                                        mid_wr_data,
    output logic [1:0]                  busy_cnt
);

    localparam int CW   = (COORD_BITS > REG_W) ? COORD_BITS : REG_W;
    localparam int IW   = CW + 3;
    localparam int XW   = IW + FRAC_BITS;
    localparam int PW   = CW + 31;
    localparam int SHR  = 31 - FRAC_BITS;
    localparam logic [PW:0] RND_C = (PW+1)'(1) << (30 - FRAC_BITS);
    localparam int QW   = 2 * CW + 6;

    // stage 1
    logic                 s1_vld_reg;
    cmd_t                 s1_cmd_reg;
    logic                 s1_on_grid_reg, s1_fold_ok_reg;
    logic signed [IW-1:0] s1_x1_reg, s1_y1_reg;
    logic [CW-1:0]        s1_ma_reg, s1_mb_reg;
    logic [CW-1:0]        s1_col_reg, s1_row_reg, s1_iy0_reg;
    logic [CW:0]          s1_a_reg, s1_b_reg;
    logic [CW+1:0]        s1_t_reg;

    logic [CW-1:0]        colx, rowx, gwx, ghx, dwx, hyx, rowf;
    logic [REG_W-1:0]     hx, hy;
    logic signed [IW-1:0] x1_c, y1_c;
    logic [IW-1:0]        x1_abs, y1_abs;
    logic                 is_rot;

    always_comb
    begin
        colx   = CW'(col);
        rowx   = CW'(row);
        gwx    = CW'(cfg.grid_width);
        ghx    = CW'(cfg.grid_height);
        dwx    = CW'(cfg.domain_width);
        hx     = cfg.grid_width >> 1;
        hy     = cfg.grid_height >> 1;
        hyx    = CW'(hy);
        x1_c   = IW'(colx) - IW'(hx);
        y1_c   = IW'(rowx) - IW'(hy);
        x1_abs = x1_c[IW-1] ? IW'(-x1_c) : IW'(x1_c);
        y1_abs = y1_c[IW-1] ? IW'(-y1_c) : IW'(y1_c);
        is_rot = (cmd_t'(cmd) == CMD_ROT_POS) || (cmd_t'(cmd) == CMD_ROT_NEG);
        rowf   = (rowx < hyx) ? CW'(ghx - 1'b1 - rowx) : rowx;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_vld)
        begin
            s1_cmd_reg     <= cmd_t'(cmd);
            s1_on_grid_reg <= (colx < gwx) && (rowx < ghx);
            s1_fold_ok_reg <= (colx < dwx);
            s1_x1_reg      <= x1_c;
            s1_y1_reg      <= y1_c;
            s1_ma_reg      <= is_rot ? x1_abs[CW-1:0] : gwx;
            s1_mb_reg      <= y1_abs[CW-1:0];
            s1_col_reg     <= colx;
            s1_row_reg     <= rowx;
            s1_iy0_reg     <= CW'(rowf - hyx);
            s1_a_reg       <= (CW+1)'({CW'(rowf - hyx), 1'b1});
            s1_b_reg       <= (CW+1)'(colx) + (CW+1)'(dwx);
            s1_t_reg       <= (CW+2)'({dwx, 1'b0}) - 1'b1 - (CW+2)'({colx, 1'b0});
        end
    end

    // stage 2: products
    logic                 s2_vld_reg;
    cmd_t                 s2_cmd_reg;
    logic                 s2_on_grid_reg, s2_fold_ok_reg;
    logic signed [IW-1:0] s2_x1_reg, s2_y1_reg;
    logic [CW-1:0]        s2_col_reg, s2_row_reg;
    logic [PW-1:0]        s2_pa_reg, s2_pb_reg;
    logic [2*CW+1:0]      s2_a2_reg, s2_b2_reg;
    logic [2*CW+3:0]      s2_t2_reg;
    logic [2*CW-1:0]      s2_i2_reg;
    logic [IDX_W-1:0]     s2_fidx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_vld_reg)
        begin
            s2_cmd_reg     <= s1_cmd_reg;
            s2_on_grid_reg <= s1_on_grid_reg;
            s2_fold_ok_reg <= s1_fold_ok_reg;
            s2_x1_reg      <= s1_x1_reg;
            s2_y1_reg      <= s1_y1_reg;
            s2_col_reg     <= s1_col_reg;
            s2_row_reg     <= s1_row_reg;
            s2_pa_reg      <= PW'(s1_ma_reg) * PW'(SQRT3_Q30);
            s2_pb_reg      <= PW'(s1_mb_reg) * PW'(SQRT3_Q30);
            s2_a2_reg      <= (2*CW+2)'(s1_a_reg) * (2*CW+2)'(s1_a_reg);
            s2_b2_reg      <= (2*CW+2)'(s1_b_reg) * (2*CW+2)'(s1_b_reg);
            s2_t2_reg      <= (2*CW+4)'(s1_t_reg) * (2*CW+4)'(s1_t_reg);
            s2_i2_reg      <= (2*CW)'(s1_iy0_reg) * (2*CW)'(s1_iy0_reg);
            s2_fidx_reg    <= IDX_W'(IDX_W'(s1_iy0_reg)
                              + IDX_W'(cfg.domain_height) * IDX_W'(s1_col_reg));
        end
    end

    // stage 3: source point and domain test, into the mid queue
    logic [PW:0]          pa_sum, pb_sum;
    logic [XW-1:0]        ra, rb;
    logic signed [XW-1:0] sa, sb, x1h, y1h, hxq, hyq, colq, rowq, xs, ys;
    logic [QW-1:0]        lhs1, rhs1, lhs2, rhs2;
    logic                 in_dom;
    kind_t                kind;

    always_comb
    begin
        pa_sum = {1'b0, s2_pa_reg} + RND_C;
        pb_sum = {1'b0, s2_pb_reg} + RND_C;
        ra     = XW'(pa_sum >> SHR);
        rb     = XW'(pb_sum >> SHR);
        sa     = s2_x1_reg[IW-1] ? -$signed(ra) : $signed(ra);
        sb     = s2_y1_reg[IW-1] ? -$signed(rb) : $signed(rb);
        x1h    = $signed({{FRAC_BITS{s2_x1_reg[IW-1]}}, s2_x1_reg}) <<< (FRAC_BITS - 1);
        y1h    = $signed({{FRAC_BITS{s2_y1_reg[IW-1]}}, s2_y1_reg}) <<< (FRAC_BITS - 1);
        hxq    = $signed(XW'(cfg.grid_width >> 1) << FRAC_BITS);
        hyq    = $signed(XW'(cfg.grid_height >> 1) << FRAC_BITS);
        colq   = $signed(XW'(s2_col_reg) << FRAC_BITS);
        rowq   = $signed(XW'(s2_row_reg) << FRAC_BITS);
        xs     = '0;
        ys     = '0;
        case (s2_cmd_reg)
            CMD_ROT_POS:
            begin
                xs = hxq - x1h - sb;
                ys = hyq + sa - y1h;
            end
            CMD_ROT_NEG:
            begin
                xs = hxq - x1h + sb;
                ys = hyq - sa - y1h;
            end
            CMD_SH_PP:
            begin
                xs = colq + hxq;
                ys = rowq + $signed(ra);
            end
            CMD_SH_PM:
            begin
                xs = colq + hxq;
                ys = rowq - $signed(ra);
            end
            CMD_SH_MP:
            begin
                xs = colq - hxq;
                ys = rowq + $signed(ra);
            end
            CMD_SH_MM:
            begin
                xs = colq - hxq;
                ys = rowq - $signed(ra);
            end
            default:
            begin
                xs = '0;
                ys = '0;
            end
        endcase

        lhs1   = QW'(s2_a2_reg) + QW'({s2_a2_reg, 1'b0});
        rhs1   = QW'({s2_b2_reg, 2'b00});
        lhs2   = QW'({s2_i2_reg, 2'b00});
        rhs2   = QW'(s2_t2_reg) + QW'({s2_t2_reg, 1'b0});
        in_dom = s2_fold_ok_reg && (lhs1 < rhs1) && (lhs2 < rhs2);

        kind = KIND_ZERO;
        if (s2_on_grid_reg)
        begin
            case (s2_cmd_reg)
                CMD_FOLD: kind = in_dom ? KIND_FOLD : KIND_ZERO;
                CMD_NONE: kind = KIND_ZERO;
                default:  kind = KIND_BIL;
            endcase
        end
    end

    assign mid_wr_en   = s2_vld_reg;
    assign mid_wr_data = {kind, xs, ys, s2_fidx_reg};
    assign busy_cnt    = {1'b0, s1_vld_reg} + {1'b0, s2_vld_reg};

endmodule

`default_nettype wire

FILE: rtl/rbw_back.sv
// ----------------------------------------------------------------------------
// rbw_back
// Takes a source point from the mid queue, forms four neighbor indices and Q16
// weights or one fold index of weight one; two steps, into the output queue.
// ----------------------------------------------------------------------------
`default_nettype none

module rbw_back
    import rbw_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire cfg_t   cfg,
    input  wire logic   mid_rd_en,
    input  wire logic [2+2*(((COORD_BITS > REG_W) ? COORD_BITS : REG_W)+3+FRAC_BITS)+IDX_W-1:0]
                        mid_rd_data,
    output logic        out_wr_en,
    output res_t        out_wr_data,
    output logic        busy
);

    localparam int CW    = (COORD_BITS > REG_W) ? COORD_BITS : REG_W;
    localparam int IW    = CW + 3;
    localparam int XW    = IW + FRAC_BITS;
    localparam int FW    = FRAC_BITS + 1;
    localparam int WPW   = 2 * FW;
    localparam int SH    = 2 * FRAC_BITS - 16;
    localparam logic [WPW:0]    WRND = (WPW+1)'((1 << SH) >> 1);
    localparam logic [FW-1:0]   ONE  = FW'(1) << FRAC_BITS;

    kind_t                kind;
    logic signed [XW-1:0] xs, ys;
    logic [IDX_W-1:0]     fidx;
    logic [FRAC_BITS-1:0] fx, fy;
    logic [IW-1:0]        x0, y0;
    logic [IW:0]          x1n, y1n;
    logic                 ok;
    logic [FW-1:0]        ofx, ofy;

    always_comb
    begin
        kind = kind_t'(mid_rd_data[2*XW+IDX_W +: 2]);
        xs   = $signed(mid_rd_data[XW+IDX_W +: XW]);
        ys   = $signed(mid_rd_data[IDX_W +: XW]);
        fidx = mid_rd_data[IDX_W-1:0];
        fx   = xs[FRAC_BITS-1:0];
        fy   = ys[FRAC_BITS-1:0];
        x0   = xs[XW-1:FRAC_BITS];
        y0   = ys[XW-1:FRAC_BITS];
        x1n  = (IW+1)'(x0) + (IW+1)'(fx != '0);
        y1n  = (IW+1)'(y0) + (IW+1)'(fy != '0);
        ok   = !xs[XW-1] && !ys[XW-1]
               && (x1n < (IW+1)'(cfg.grid_width)) && (y1n < (IW+1)'(cfg.grid_height));
        ofx  = ONE - FW'(fx);
        ofy  = ONE - FW'(fy);
    end

    logic             b1_vld_reg;
    kind_t            b1_kind_reg;
    logic             b1_ok_reg, b1_dx_reg, b1_dy_reg;
    logic [IDX_W-1:0] b1_ghx0_reg, b1_fidx_reg;
    logic [REG_W-1:0] b1_y0_reg;
    logic [WPW-1:0]   b1_pa_reg, b1_pb_reg, b1_pc_reg, b1_pd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_vld_reg <= 1'b0;
        end
        else
        begin
            b1_vld_reg <= mid_rd_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mid_rd_en)
        begin
            b1_kind_reg <= kind;
            b1_ok_reg   <= ok;
            b1_dx_reg   <= (fx != '0);
            b1_dy_reg   <= (fy != '0);
            b1_ghx0_reg <= IDX_W'(IDX_W'(cfg.grid_height) * IDX_W'(x0[REG_W-1:0]));
            b1_y0_reg   <= y0[REG_W-1:0];
            b1_fidx_reg <= fidx;
            b1_pa_reg   <= WPW'(ofx) * WPW'(ofy);
            b1_pb_reg   <= WPW'(FW'(fx)) * WPW'(ofy);
            b1_pc_reg   <= WPW'(ofx) * WPW'(FW'(fy));
            b1_pd_reg   <= WPW'(FW'(fx)) * WPW'(FW'(fy));
        end
    end

    logic [IDX_W-1:0] ia, ib, ic, id;
    logic [WPW:0]     wa, wb, wc, wd;
    res_t             res;

    always_comb
    begin
        ia = b1_ghx0_reg + IDX_W'(b1_y0_reg);
        ib = ia + (b1_dx_reg ? IDX_W'(cfg.grid_height) : '0);
        ic = ia + IDX_W'(b1_dy_reg);
        id = ib + IDX_W'(b1_dy_reg);
        wa = ({1'b0, b1_pa_reg} + WRND) >> SH;
        wb = ({1'b0, b1_pb_reg} + WRND) >> SH;
        wc = ({1'b0, b1_pc_reg} + WRND) >> SH;
        wd = ({1'b0, b1_pd_reg} + WRND) >> SH;
        res = '0;
        case (b1_kind_reg)
            KIND_BIL:
            begin
                if (b1_ok_reg)
                begin
                    res.in_range = 1'b1;
                    res.index_a  = ia;
                    res.index_b  = ib;
                    res.index_c  = ic;
                    res.index_d  = id;
                    res.weight_a = wa[WGT_W-1:0];
                    res.weight_b = wb[WGT_W-1:0];
                    res.weight_c = wc[WGT_W-1:0];
                    res.weight_d = wd[WGT_W-1:0];
                end
            end
            KIND_FOLD:
            begin
                res.in_range = 1'b1;
                res.index_a  = b1_fidx_reg;
                res.weight_a = WGT_ONE;
            end
            default:
            begin
                res = '0;
            end
        endcase
    end

    assign out_wr_en   = b1_vld_reg;
    assign out_wr_data = res;
    assign busy        = b1_vld_reg;

endmodule

`default_nettype wire

FILE: rtl/rotation_bilinear_weight_gen_top.sv
// ----------------------------------------------------------------------------
// rotation_bilinear_weight_gen_top
// Bilinear source indices and weights for 120-degree rotation, shift and
// fold mapping of a pixel grid.
// ----------------------------------------------------------------------------
//  channel   direction  handshake           payload
//  input     in         push / full         cmd, col, row
//  result    out        pop / empty         in_range, index_a..d, weight_a..d
//  config    in         cfg_wr_en           cfg_addr, cfg_wr_data
//
//  One transaction per cycle sustained while results are popped; a result
//  reaches the output queue through two front stages, mid queue, back stage.
//  The front stalls only when its queue credit runs out; the back stops
//  reading when the 4-entry output queue has no room.
//  rst_n is asynchronous; the config registers return to their reset sizes.
// ----------------------------------------------------------------------------
`default_nettype none

module rotation_bilinear_weight_gen_top
    import rbw_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    output logic                        full,
    input  wire logic [CMD_W-1:0]       cmd,
    input  wire logic [COORD_BITS-1:0]  col,
    input  wire logic [COORD_BITS-1:0]  row,
    output logic                        empty,
    input  wire logic                   pop,
    output logic                        in_range,
    output logic [IDX_W-1:0]            index_a,
    output logic [IDX_W-1:0]            index_b,
    output logic [IDX_W-1:0]            index_c,
    output logic [IDX_W-1:0]            index_d,
    output logic [WGT_W-1:0]            weight_a,
    output logic [WGT_W-1:0]            weight_b,
    output logic [WGT_W-1:0]            weight_c,
    output logic [WGT_W-1:0]            weight_d,
    input  wire logic                   cfg_wr_en,
    input  wire logic [REG_IDX_W-1:0]   cfg_addr,
    input  wire logic [REG_W-1:0]       cfg_wr_data
);

    localparam int CW   = (COORD_BITS > REG_W) ? COORD_BITS : REG_W;
    localparam int XW   = CW + 3 + FRAC_BITS;
    localparam int MIDW = 2 + 2 * XW + IDX_W;
    localparam int CNTW = $clog2(FIFO_DEPTH) + 1;

    cfg_t cfg_reg, cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (reg_idx_t'(cfg_addr))
                REG_GRID_W: cfg_next.grid_width    = cfg_wr_data;
                REG_GRID_H: cfg_next.grid_height   = cfg_wr_data;
                REG_DOM_W:  cfg_next.domain_width  = cfg_wr_data;
                REG_DOM_H:  cfg_next.domain_height = cfg_wr_data;
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{RST_GRID_W, RST_GRID_H, RST_DOM_W, RST_DOM_H};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    logic             in_vld;
    logic             mid_wr_en, mid_rd_en, mid_empty;
    logic [MIDW-1:0]  mid_wr_data, mid_rd_data;
    logic [CNTW-1:0]  mid_cnt, out_cnt;
    logic [1:0]       front_busy;
    logic             back_busy, out_wr_en, out_rd_en;
    res_t             out_wr_data, out_rd_data;

    assign full      = (CNTW+1)'(mid_cnt) + (CNTW+1)'(front_busy) >= (CNTW+1)'(FIFO_DEPTH);
    assign in_vld    = push && !full;
    assign mid_rd_en = !mid_empty
                       && ((CNTW+1)'(out_cnt) + (CNTW+1)'(back_busy) < (CNTW+1)'(FIFO_DEPTH));
    assign out_rd_en = pop && !empty;

    rbw_front #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_vld      (in_vld),
        .cmd         (cmd),
        .col         (col),
        .row         (row),
        .mid_wr_en   (mid_wr_en),
        .mid_wr_data (mid_wr_data),
        .busy_cnt    (front_busy)
    );

    rbw_fifo #(
        .WIDTH (MIDW),
        .DEPTH (FIFO_DEPTH)
    ) u_mid_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (mid_wr_en),
        .wr_data (mid_wr_data),
        .rd_en   (mid_rd_en),
        .rd_data (mid_rd_data),
        .count   (mid_cnt),
        .empty   (mid_empty)
    );

    rbw_back #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .mid_rd_en   (mid_rd_en),
        .mid_rd_data (mid_rd_data),
        .out_wr_en   (out_wr_en),
        .out_wr_data (out_wr_data),
        .busy        (back_busy)
    );

    rbw_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (FIFO_DEPTH)
    ) u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (out_wr_en),
        .wr_data (out_wr_data),
        .rd_en   (out_rd_en),
        .rd_data (out_rd_data),
        .count   (out_cnt),
        .empty   (empty)
    );

    assign in_range = out_rd_data.in_range;
    assign index_a  = out_rd_data.index_a;
    assign index_b  = out_rd_data.index_b;
    assign index_c  = out_rd_data.index_c;
    assign index_d  = out_rd_data.index_d;
    assign weight_a = out_rd_data.weight_a;
    assign weight_b = out_rd_data.weight_b;
    assign weight_c = out_rd_data.weight_c;
    assign weight_d = out_rd_data.weight_d;

endmodule

`default_nettype wire

FILE: rtl/rbw_checker.sv
// ----------------------------------------------------------------------------
// rbw_port_checker
// Port-level checks of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rbw_port_checker
    import rbw_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              empty,
    input  wire logic              pop,
    input  wire logic              in_range,
    input  wire logic [IDX_W-1:0]  index_a,
    input  wire logic [IDX_W-1:0]  index_d,
    input  wire logic [WGT_W-1:0]  weight_a,
    input  wire logic [WGT_W-1:0]  weight_b,
    input  wire logic [WGT_W-1:0]  weight_c,
    input  wire logic [WGT_W-1:0]  weight_d
);

    logic [WGT_W+1:0] wsum;

    assign wsum = (WGT_W+2)'(weight_a) + (WGT_W+2)'(weight_b)
                + (WGT_W+2)'(weight_c) + (WGT_W+2)'(weight_d);

    // a rejected transaction carries zero index_a, index_d and weights
    a_zero_when_out: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !in_range) |-> (index_a == '0 && index_d == '0 && wsum == '0))
        else $error("rejected transaction has nonzero payload");

    // weights of an accepted point sum to one within rounding
    a_weight_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && in_range) |-> (wsum >= 19'd65534 && wsum <= 19'd65538))
        else $error("weight sum off");

    a_weight_max: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (weight_a <= WGT_ONE && weight_b <= WGT_ONE
                    && weight_c <= WGT_ONE && weight_d <= WGT_ONE))
        else $error("weight above one");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(index_a) && $stable(weight_a)))
        else $error("waiting result changed");

endmodule

bind rotation_bilinear_weight_gen_top rbw_port_checker u_rbw_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .empty    (empty),
    .pop      (pop),
    .in_range (in_range),
    .index_a  (index_a),
    .index_d  (index_d),
    .weight_a (weight_a),
    .weight_b (weight_b),
    .weight_c (weight_c),
    .weight_d (weight_d)
);

`default_nettype wire
